>>> src/i2p_pkg.sv
// shared types, character codes and helper functions for the infix to postfix converter
// used by i2p_ctrl, i2p_datapath and infix_to_postfix_converter; no dependencies
`default_nettype none

package i2p_pkg;

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the input transaction
    logic push;        // push the held character
    logic pop;         // drop the stack top
    logic rd_en;       // read the stack top into the read register
    logic emit_char;   // held character goes to the pending result
    logic emit_top;    // read register goes to the pending result
    logic send_final;  // close the item: pending result or bare marker to output
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_letter;
    logic is_open;
    logic is_close;
    logic eoe;
    logic count_zero;
    logic top_is_open;
    logic top_pops;    // stack top outranks the held operator, or ties it when the held one is not caret
    logic emit_ok;
    logic out_free;
    logic pend_valid;
  } stat_t;

  // precedence rank; "other" ranks lowest as zero
  function automatic logic [1:0] rank(input logic [7:0] c);
    logic [1:0] r;
    r = 2'd0;
    if (c == CH_CARET) begin
      r = 2'd3;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      r = 2'd2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      r = 2'd1;
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

endpackage

`default_nettype wire

>>> src/infix_to_postfix_converter.sv
// each character walks the controller states from dispatch to finish before the next is taken;
// every popped or flushed stack entry adds a read and a check state, as the stack read is registered
// reset: synchronous, clears the stack count, the overflow flag, the pending flag and output valid;
// the controller returns to idle; the stack memory is not cleared and is never read below an unwritten entry
`default_nettype none

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_in
  input  wire logic        s_tlast,   // end_of_expr
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] char_out, [8] overflow, [15:9] zero
  output logic             m_tlast,   // last_out
  output logic             m_tuser    // has_char
);

  i2p_pkg::cmd_t  cmd;
  i2p_pkg::stat_t stat;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  i2p_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // nothing of a previous character is left pending when a new one is taken
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !stat.pend_valid)
    else $error("pending result left over while idle");

  // a bare end marker is always the final result of its expression
  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("bare marker without last flag");

  // the controller never issues two of load, push, pop, emit_char and send_final at once
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.push, cmd.pop, cmd.emit_char, cmd.send_final}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

>>> src/i2p_ctrl.sv
// controller state machine of the infix to postfix converter
// depends on i2p_pkg (cmd_t, stat_t)
`default_nettype none

module i2p_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire i2p_pkg::stat_t stat,
  output i2p_pkg::cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_READ     = 8'b0000_0100,
    S_CHECK    = 8'b0000_1000,
    S_TAIL     = 8'b0001_0000,
    S_FREAD    = 8'b0010_0000,
    S_FCHECK   = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_letter) begin
          if (stat.emit_ok) begin
            cmd.emit_char = 1'b1;
            state_next    = S_TAIL;
          end
        end else if (stat.is_open) begin
          cmd.push   = 1'b1;
          state_next = S_TAIL;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.count_zero) begin
          // close paren with nothing left, or operator on an empty stack
          cmd.push   = !stat.is_close;
          state_next = S_TAIL;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_close && stat.top_is_open) begin
          cmd.pop    = 1'b1;
          state_next = S_TAIL;
        end else if (!stat.is_close && (stat.top_is_open || !stat.top_pops)) begin
          cmd.push   = 1'b1;
          state_next = S_TAIL;
        end else if (stat.emit_ok) begin
          cmd.pop      = 1'b1;
          cmd.emit_top = 1'b1;
          state_next   = S_READ;
        end
      end
      S_TAIL: begin
        state_next = stat.eoe ? S_FREAD : S_FINISH;
      end
      S_FREAD: begin
        if (stat.count_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_FCHECK;
        end
      end
      S_FCHECK: begin
        if (stat.emit_ok) begin
          cmd.pop      = 1'b1;
          cmd.emit_top = 1'b1;
          state_next   = S_FREAD;
        end
      end
      S_FINISH: begin
        if (stat.pend_valid || stat.eoe) begin
          if (stat.out_free) begin
            cmd.send_final = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/i2p_datapath.sv
// datapath of the infix to postfix converter: operator stack memory, count,
// overflow flag, one pending result and the output register; depends on i2p_pkg
`default_nettype none

module i2p_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [7:0]     s_tdata,
  input  wire logic           s_tlast,
  input  wire i2p_pkg::cmd_t  cmd,
  output i2p_pkg::stat_t      stat,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [15:0]         m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic [7:0]    mem [STACK_DEPTH];
  logic [7:0]    ch;
  logic          eoe;
  logic [7:0]    rd_data;
  logic [CW-1:0] count;
  logic [CW-1:0] count_dec;
  logic          ovf;
  logic          full;
  logic [7:0]    pend_char;
  logic          pend_valid;
  logic          out_free;
  logic          emit;
  logic          load_out;

  assign full      = (count == DEPTH_C);
  assign count_dec = count - CW'(1);
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = cmd.emit_char || cmd.emit_top;
  // the pending result moves out when a newer one replaces it or the item closes
  assign load_out  = (emit && pend_valid) || cmd.send_final;

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[count[AW-1:0]] <= ch;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[count_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch  <= s_tdata;
      eoe <= s_tlast;
    end
    if (emit) begin
      pend_char <= cmd.emit_char ? ch : rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ovf        <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.send_final && eoe) begin
        count <= '0;
        ovf   <= 1'b0;
      end else if (cmd.push) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end else if (cmd.pop) begin
        count <= count_dec;
      end
      if (emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.send_final) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {7'd0, ovf, (pend_valid ? pend_char : 8'd0)};
      m_tuser <= pend_valid;
      m_tlast <= cmd.send_final && eoe;
    end
  end

  always_comb begin
    stat             = '0;
    stat.is_letter   = i2p_pkg::is_letter(ch);
    stat.is_open     = (ch == i2p_pkg::CH_LPAREN);
    stat.is_close    = (ch == i2p_pkg::CH_RPAREN);
    stat.eoe         = eoe;
    stat.count_zero  = (count == '0);
    stat.top_is_open = (rd_data == i2p_pkg::CH_LPAREN);
    // right-associative caret does not pop its equal
    stat.top_pops    = (i2p_pkg::rank(rd_data) > i2p_pkg::rank(ch)) ||
                       ((i2p_pkg::rank(rd_data) == i2p_pkg::rank(ch)) &&
                        (ch != i2p_pkg::CH_CARET));
    stat.emit_ok     = !pend_valid || out_free;
    stat.out_free    = out_free;
    stat.pend_valid  = pend_valid;
  end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for infix_to_postfix_converter: directed and random expressions
// with a built-in operator-stack predictor and random stalls on both stream sides
// depends on i2p_pkg (character codes) and the converter RTL
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH  = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
    logic       ovf;
  } postfix_out_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  // operator stack mirror and the postfix characters still owed by the block
  logic [7:0]   op_stack [STACK_DEPTH];
  int           op_depth = 0;
  logic         ovf_flag = 1'b0;
  postfix_out_t postfix_q[$];

  int   errors = 0;
  int   chars_sent = 0;
  int   expressions = 0;
  int   results_checked = 0;
  int   ovf_results = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  logic hold_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  function automatic int op_rank(input logic [7:0] c);
    if (c == i2p_pkg::CH_CARET) return 3;
    if (c == i2p_pkg::CH_STAR || c == i2p_pkg::CH_SLASH) return 2;
    if (c == i2p_pkg::CH_PLUS || c == i2p_pkg::CH_MINUS) return 1;
    return -1;
  endfunction

  // shunting-yard step for one accepted transaction
  function automatic void convert_char(input logic [7:0] c, input logic eoe);
    logic [7:0]   emitted[$];
    logic [7:0]   top;
    postfix_out_t r;
    bit           done;
    if ((c >= i2p_pkg::CH_UP_A && c <= i2p_pkg::CH_UP_Z) ||
        (c >= i2p_pkg::CH_LO_A && c <= i2p_pkg::CH_LO_Z)) begin
      emitted.push_back(c);
    end else if (c == i2p_pkg::CH_RPAREN) begin
      while (op_depth > 0 && op_stack[op_depth-1] != i2p_pkg::CH_LPAREN) begin
        op_depth--;
        emitted.push_back(op_stack[op_depth]);
      end
      if (op_depth > 0) op_depth--;
    end else begin
      if (c != i2p_pkg::CH_LPAREN) begin
        done = 1'b0;
        while (op_depth > 0 && !done) begin
          top = op_stack[op_depth-1];
          // popping stops at an open parenthesis; '^' is right-associative
          if (top != i2p_pkg::CH_LPAREN && (op_rank(top) > op_rank(c) ||
              (op_rank(top) == op_rank(c) && c != i2p_pkg::CH_CARET))) begin
            emitted.push_back(top);
            op_depth--;
          end else begin
            done = 1'b1;
          end
        end
      end
      if (op_depth >= STACK_DEPTH) begin
        ovf_flag = 1'b1;
      end else begin
        op_stack[op_depth] = c;
        op_depth++;
      end
    end
    if (eoe) begin
      while (op_depth > 0) begin
        op_depth--;
        emitted.push_back(op_stack[op_depth]);
      end
    end
    foreach (emitted[i]) begin
      r.ch       = emitted[i];
      r.has_char = 1'b1;
      r.last     = eoe && (i == emitted.size() - 1);
      r.ovf      = ovf_flag;
      postfix_q.push_back(r);
    end
    if (eoe && emitted.size() == 0) begin
      // bare end marker
      r.ch       = 8'h00;
      r.has_char = 1'b0;
      r.last     = 1'b1;
      r.ovf      = ovf_flag;
      postfix_q.push_back(r);
    end
    if (eoe) begin
      op_depth = 0;
      ovf_flag = 1'b0;
      expressions++;
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    postfix_out_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        convert_char(s_tdata, s_tlast);
        chars_sent++;
      end
      if (m_tvalid && m_tready) begin
        if (postfix_q.size() == 0) begin
          $error("result with no expectation: char_out 0x%0h", m_tdata[7:0]);
          errors++;
        end else begin
          want = postfix_q.pop_front();
          check_field("char_out", 16'(want.ch), 16'(m_tdata[7:0]));
          check_field("overflow", 16'(want.ovf), 16'(m_tdata[8]));
          check_field("tdata padding", 16'h0, 16'(m_tdata[15:9]));
          check_field("has_char", 16'(want.has_char), 16'(m_tuser));
          check_field("last_out", 16'(want.last), 16'(m_tlast));
          if (want.ovf) ovf_results++;
        end
        results_checked++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("testbench: no transaction for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, postfix_q.size());
    $display("testbench: FAIL");
    $finish;
  end

  // output side: stall pattern changes every so often, long hold-off on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    mode = RX_OPEN;
    mode_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_OPEN: begin
            m_tready = 1'b1;
          end
          RX_COIN: begin
            m_tready = 1'($urandom_range(0, 1));
          end
          RX_SPARSE: begin
            m_tready = (phase % 5 == 0);
          end
          default: begin
            m_tready = ($urandom_range(0, 9) != 0);
          end
        endcase
      end
    end
  end

  // input side sends in bursts with random gaps between them
  task automatic send_char(input logic [7:0] c, input logic eoe);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = c;
    s_tlast  = eoe;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_seq(input logic [7:0] q[$], input logic close);
    foreach (q[i]) send_char(q[i], close && (i == q.size() - 1));
  endtask

  task automatic send_text(input string s, input logic close);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_seq(q, close);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    burst_left = 0;
    while (postfix_q.size() != 0) @(negedge clk);
  endtask

  // well-formed infix: terms joined by operators, some terms parenthesized
  function automatic void gen_expr(ref logic [7:0] q[$], input int depth);
    string ops;
    int    terms;
    ops = "^*/+-";
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) q.push_back(ops[$urandom_range(0, 4)]);
      if (depth > 0 && $urandom_range(0, 3) == 0) begin
        q.push_back(i2p_pkg::CH_LPAREN);
        gen_expr(q, depth - 1);
        q.push_back(i2p_pkg::CH_RPAREN);
      end else if ($urandom_range(0, 1) == 1) begin
        q.push_back(8'($urandom_range(i2p_pkg::CH_UP_A, i2p_pkg::CH_UP_Z)));
      end else begin
        q.push_back(8'($urandom_range(i2p_pkg::CH_LO_A, i2p_pkg::CH_LO_Z)));
      end
    end
  endfunction

  task automatic test_letters();
    send_text("AZaz", 1'b1);
    // neighbors of the letter ranges and the code extremes rank as lowest operators
    send_text("@[`{", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_precedence();
    send_text("a^b^c*d/e-f+g", 1'b1);
  endtask

  task automatic test_parentheses();
    send_text("a*(b+c)", 1'b1);
    // end mark with nothing to emit
    send_text(")", 1'b1);
    // close with no open on the stack
    send_text("a+b)c", 1'b1);
    send_text("((a", 1'b1);
  endtask

  task automatic test_full_stack();
    repeat (STACK_DEPTH + 1) send_char(i2p_pkg::CH_LPAREN, 1'b0);
    send_text("ab", 1'b1);
    send_text("c", 1'b1);
    // a full stack of powers flushed by the last operand
    send_char("a", 1'b0);
    repeat (STACK_DEPTH - 1) send_text("^b", 1'b0);
    send_text("^b", 1'b1);
  endtask

  task automatic test_backpressure();
    logic [7:0] q[$];
    hold_req = 1'b1;
    repeat (4) begin
      q.delete();
      gen_expr(q, 3);
      send_seq(q, 1'b1);
    end
    wait (hold_req == 1'b0);
    wait_drain();
  endtask

  task automatic test_random();
    logic [7:0] q[$];
    int         kind;
    int         pos;
    int         sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      q.delete();
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      end else begin
        gen_expr(q, 3);
        // a few sequences lose a character or gain a stray parenthesis
        if (kind < 5) begin
          pos = $urandom_range(0, q.size() - 1);
          if (kind == 3 && q.size() > 1) q.delete(pos);
          else q.insert(pos, $urandom_range(0, 1) ? i2p_pkg::CH_LPAREN
                                                  : i2p_pkg::CH_RPAREN);
        end
      end
      send_seq(q, $urandom_range(0, 7) != 0);
      sent += q.size();
      if ($urandom_range(0, 15) == 0) wait_drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_letters();
    test_precedence();
    test_parentheses();
    test_full_stack();
    test_backpressure();
    test_random();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("testbench: %0d characters in %0d expressions, %0d results checked",
             chars_sent, expressions, results_checked);
    $display("testbench: %0d results carried the overflow flag, %0d mismatches",
             ovf_results, errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
